// ===== rtl/pgta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgta_pkg
// Shared constants and types for the proximity gated temperature averager.
// ----------------------------------------------------------------------------
package pgta_pkg;

   localparam int WINDOW  = 8;
   localparam int DIST_W  = 13;
   localparam int TEMP_W  = 16;
   localparam int GAIN_W  = 16;
   localparam int CSR_W   = 16;
   localparam int IDX_W   = 3;
   localparam int SUM_W   = TEMP_W + $clog2(WINDOW);
   localparam int COUNT_W = $clog2(WINDOW + 1);

   localparam logic [IDX_W-1:0] REG_NEAR_MIN   = 3'd0;
   localparam logic [IDX_W-1:0] REG_NEAR_MAX   = 3'd1;
   localparam logic [IDX_W-1:0] REG_PROMPT_MAX = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAIN       = 3'd3;
   localparam logic [IDX_W-1:0] REG_THRESHOLD  = 3'd4;

   typedef struct packed {
      logic                     taken;
      logic                     prompt;
      logic signed [TEMP_W-1:0] comp;
   } front_type;

endpackage

// ===== rtl/pgta_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgta_cell
// One entry of the sample window; takes its neighbour's value, or the new sample, on a shift.
// ----------------------------------------------------------------------------
module pgta_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  logic signed [pgta_pkg::TEMP_W-1:0] d_in,
   output logic signed [pgta_pkg::TEMP_W-1:0] q
);
   import pgta_pkg::*;

   logic signed [TEMP_W-1:0] value_ff;
   logic signed [TEMP_W-1:0] value_in;

   always_comb begin
      value_in = shift_en ? d_in : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign q = value_ff;

endmodule

// ===== rtl/pgta_comp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgta_comp
// Front stage: window checks and distance compensation of one item.
// ----------------------------------------------------------------------------
module pgta_comp (
   input  logic                               clock,
   input  logic                               load_en,
   input  logic        [pgta_pkg::DIST_W-1:0] distance_mm,
   input  logic signed [pgta_pkg::TEMP_W-1:0] object_temp,
   input  logic        [pgta_pkg::DIST_W-1:0] near_min_mm,
   input  logic        [pgta_pkg::DIST_W-1:0] near_max_mm,
   input  logic        [pgta_pkg::DIST_W-1:0] prompt_max_mm,
   input  logic        [pgta_pkg::GAIN_W-1:0] distance_gain,
   output pgta_pkg::front_type                front
);
   import pgta_pkg::*;

   localparam int PROD_W = DIST_W + GAIN_W;
   localparam int ADJ_W  = PROD_W - 8;
   localparam int TOT_W  = ADJ_W + 2;
   localparam logic signed [TOT_W-1:0] SAT_HI = TOT_W'(32767);
   localparam logic signed [TOT_W-1:0] SAT_LO = -TOT_W'(32768);

   logic        [PROD_W-1:0] prod;
   logic signed [TOT_W-1:0]  total;
   front_type                front_ff;
   front_type                front_in;

   always_comb begin
      prod  = PROD_W'(distance_mm) * PROD_W'(distance_gain);
      total = TOT_W'(object_temp) + $signed({2'b00, prod[PROD_W-1:8]});
      front_in.taken  = (distance_mm > near_min_mm) && (distance_mm < near_max_mm);
      front_in.prompt = (distance_mm > near_max_mm) && (distance_mm < prompt_max_mm);
      if (total > SAT_HI) begin
         front_in.comp = TEMP_W'(SAT_HI);
      end else if (total < SAT_LO) begin
         front_in.comp = TEMP_W'(SAT_LO);
      end else begin
         front_in.comp = total[TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

// ===== rtl/proximity_gated_temperature_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_gated_temperature_averager
// Gates sensor ticks by distance, averages compensated temperatures over a
// sliding window and announces a stabilised reading.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns one
// result item per item: the front stage does the window checks and the
// distance * gain compensation multiply, and the output stage shifts the row of
// window cells, updates the running sum, mean and good count and registers the
// result. The output register lets a new item enter while a result waits.
module proximity_gated_temperature_averager (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic        [pgta_pkg::DIST_W-1:0] req_distance_mm,
   input  logic signed [pgta_pkg::TEMP_W-1:0] req_object_temp,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_announce,
   output logic signed [pgta_pkg::TEMP_W-1:0] rsp_announced_temp,
   output logic                               rsp_relay_on,
   output logic                               rsp_prompt,
   output logic                               rsp_sample_taken,
   output logic                               rsp_beep,
   output logic signed [pgta_pkg::TEMP_W-1:0] rsp_average_temp,
   input  logic                               csr_we,
   input  logic        [pgta_pkg::IDX_W-1:0]  csr_index,
   input  logic        [pgta_pkg::CSR_W-1:0]  csr_wdata
);
   import pgta_pkg::*;

   localparam logic signed [SUM_W-1:0] WindowDiv = SUM_W'(WINDOW);

   // configuration
   logic        [DIST_W-1:0] near_min_ff, near_max_ff, prompt_max_ff;
   logic        [GAIN_W-1:0] gain_ff;
   logic signed [TEMP_W-1:0] threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_min_ff   <= DIST_W'(50);
         near_max_ff   <= DIST_W'(180);
         prompt_max_ff <= DIST_W'(400);
         gain_ff       <= GAIN_W'(256);
         threshold_ff  <= TEMP_W'(3500);
      end else if (csr_we) begin
         case (csr_index)
            REG_NEAR_MIN:   near_min_ff   <= csr_wdata[DIST_W-1:0];
            REG_NEAR_MAX:   near_max_ff   <= csr_wdata[DIST_W-1:0];
            REG_PROMPT_MAX: prompt_max_ff <= csr_wdata[DIST_W-1:0];
            REG_GAIN:       gain_ff       <= csr_wdata[GAIN_W-1:0];
            REG_THRESHOLD:  threshold_ff  <= csr_wdata[TEMP_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_en, req_fire, s1_move;

   assign out_en    = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || out_en;
   assign req_fire  = req_valid && req_ready;
   assign s1_move   = s1_valid_ff && out_en;

   always_comb begin
      s1_valid_in  = req_fire || (s1_valid_ff && !out_en);
      rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   front_type front;

   pgta_comp u_comp (
      .clock         (clock),
      .load_en       (req_fire),
      .distance_mm   (req_distance_mm),
      .object_temp   (req_object_temp),
      .near_min_mm   (near_min_ff),
      .near_max_mm   (near_max_ff),
      .prompt_max_mm (prompt_max_ff),
      .distance_gain (gain_ff),
      .front         (front)
   );

   // window cells, entry 0 oldest
   logic                     shift_en;
   logic signed [TEMP_W-1:0] cell_q [WINDOW];

   assign shift_en = s1_move && front.taken;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      pgta_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .d_in     ((i == WINDOW - 1) ? front.comp : cell_q[(i + 1) % WINDOW]),
         .q        (cell_q[i])
      );
   end

   // window state and result
   logic signed [SUM_W-1:0]  sum_ff, sum_in, new_sum;
   logic        [COUNT_W-1:0] count_ff, count_in, count_base;
   logic signed [TEMP_W-1:0] held_ff, held_in, new_held;
   logic                     announce;

   logic                     rsp_announce_ff, rsp_relay_ff, rsp_prompt_ff;
   logic                     rsp_taken_ff, rsp_beep_ff;
   logic signed [TEMP_W-1:0] rsp_announced_ff, rsp_average_ff;

   always_comb begin
      announce   = count_ff > COUNT_W'(WINDOW - 1);
      count_base = announce ? '0 : count_ff;
      new_sum    = sum_ff - SUM_W'(cell_q[0]) + SUM_W'(front.comp);
      new_held   = TEMP_W'(new_sum / WindowDiv);
      sum_in     = sum_ff;
      count_in   = count_ff;
      held_in    = held_ff;
      if (s1_move) begin
         if (front.taken) begin
            sum_in   = new_sum;
            held_in  = new_held;
            count_in = count_base + COUNT_W'(1);
         end else begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         held_ff  <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_announce_ff  <= announce;
         rsp_announced_ff <= announce ? held_ff : '0;
         rsp_relay_ff     <= announce && (held_ff < threshold_ff);
         rsp_prompt_ff    <= front.prompt;
         rsp_taken_ff     <= front.taken;
         rsp_beep_ff      <= front.taken && (count_base >= COUNT_W'(2));
         rsp_average_ff   <= held_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_announce       = rsp_announce_ff;
   assign rsp_announced_temp = rsp_announced_ff;
   assign rsp_relay_on       = rsp_relay_ff;
   assign rsp_prompt         = rsp_prompt_ff;
   assign rsp_sample_taken   = rsp_taken_ff;
   assign rsp_beep           = rsp_beep_ff;
   assign rsp_average_temp   = rsp_average_ff;

`ifndef ASSERT_OFF
   // good count never passes the window depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WINDOW))
      else $error("good count out of range");

   // a moving item always lands in the output register
   a_s1_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp_valid_ff)
      else $error("item lost between stages");

   // window state frozen while the output is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> ($stable(count_ff) && $stable(sum_ff)))
      else $error("state changed during stall");

   // beep only with a taken sample
   a_beep_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_beep_ff) |-> rsp_taken_ff)
      else $error("beep without sample");
`endif

endmodule

// ===== bench/tb_proximity_gated_temperature_averager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_proximity_gated_temperature_averager
// Self-checking bench for the proximity gated temperature averager. A table of
// directed sensor ticks is followed by runs of good samples with random
// temperatures under several register settings. Every result item is checked
// field by field against the table's reading or an in-bench model of the window.
// ----------------------------------------------------------------------------
module tb_proximity_gated_temperature_averager;
   import pgta_pkg::*;

   typedef struct packed {
      logic                     announce;
      logic signed [TEMP_W-1:0] announced_temp;
      logic                     relay_on;
      logic                     prompt;
      logic                     sample_taken;
      logic                     beep;
      logic signed [TEMP_W-1:0] average_temp;
   } reading_type;

   typedef struct packed {
      logic        [DIST_W-1:0] distance;
      logic signed [TEMP_W-1:0] temp;
      logic                     known;
      reading_type              want;
   } plan_row_type;

   localparam reading_type QUIET    = '0;
   localparam reading_type PROMPTED = '{1'b0, 16'sd0, 1'b0, 1'b1, 1'b0, 1'b0, 16'sd0};
   localparam reading_type FIRST    = '{1'b0, 16'sd0, 1'b0, 1'b0, 1'b1, 1'b0, 16'sd6};

   localparam int PLAN_ROWS   = 25;
   localparam int PHASES      = 11;
   localparam int PHASE_ITEMS = 150;

   localparam plan_row_type TICK_PLAN [PLAN_ROWS] = '{
      '{13'd0,    16'sh0000, 1'b1, QUIET},
      '{13'd8191, 16'sh8000, 1'b1, QUIET},
      '{13'd50,   16'sd1234, 1'b1, QUIET},
      '{13'd180,  16'shFFFF, 1'b1, QUIET},
      '{13'd400,  16'sh7FFF, 1'b1, QUIET},
      '{13'd181,  16'sh0000, 1'b1, PROMPTED},
      '{13'd399,  16'sh8000, 1'b1, PROMPTED},
      '{13'd51,   16'sh0000, 1'b1, FIRST},
      '{13'd179,  16'sh7FFF, 1'b0, QUIET},
      '{13'd100,  16'sh8000, 1'b0, QUIET},
      '{13'd120,  16'sd5555, 1'b0, QUIET},
      '{13'd60,   16'shB1E0, 1'b0, QUIET},
      '{13'd170,  16'sd3000, 1'b0, QUIET},
      '{13'd130,  16'shFFFF, 1'b0, QUIET},
      '{13'd90,   16'sd12000, 1'b0, QUIET},
      '{13'd140,  16'sd4000, 1'b0, QUIET},
      '{13'd51,   16'shEC78, 1'b0, QUIET},
      '{13'd179,  16'shF060, 1'b0, QUIET},
      '{13'd100,  16'shF448, 1'b0, QUIET},
      '{13'd65,   16'shF830, 1'b0, QUIET},
      '{13'd175,  16'shFC18, 1'b0, QUIET},
      '{13'd150,  16'shFE0C, 1'b0, QUIET},
      '{13'd52,   16'sh8000, 1'b0, QUIET},
      '{13'd300,  16'sh0000, 1'b0, QUIET},
      '{13'd8191, 16'sh0000, 1'b0, QUIET}
   };

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic        [DIST_W-1:0] req_distance_mm = '0;
   logic signed [TEMP_W-1:0] req_object_temp = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_announce;
   logic signed [TEMP_W-1:0] rsp_announced_temp;
   logic                     rsp_relay_on;
   logic                     rsp_prompt;
   logic                     rsp_sample_taken;
   logic                     rsp_beep;
   logic signed [TEMP_W-1:0] rsp_average_temp;
   logic                     csr_we = 1'b0;
   logic        [IDX_W-1:0]  csr_index = '0;
   logic        [CSR_W-1:0]  csr_wdata = '0;

   // model copy of the registers and the averaging state
   logic        [DIST_W-1:0] cfg_near_min   = 13'd50;
   logic        [DIST_W-1:0] cfg_near_max   = 13'd180;
   logic        [DIST_W-1:0] cfg_prompt_max = 13'd400;
   logic        [GAIN_W-1:0] cfg_gain       = 16'd256;
   logic signed [TEMP_W-1:0] cfg_threshold  = 16'sd3500;
   int                       win_cells [WINDOW] = '{default: 0};
   int                       win_total = 0;
   int                       streak = 0;
   logic signed [TEMP_W-1:0] held_avg = '0;

   reading_type pending_readings [$];
   int       items_sent = 0;
   int       send_idle_pct = 0;
   int       rcv_idle_pct = 0;
   logic     hold_trigger = 1'b0;
   bit       hold_asked = 0;
   bit       hold_taken = 0;
   int       hold_left = 0;
   int       mismatches = 0;
   int       checked_total = 0;
   int       announce_seen = 0;
   int       relay_seen = 0;
   int       beep_seen = 0;
   int       saturated_total = 0;
   int       settings_used = 0;

   proximity_gated_temperature_averager dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_distance_mm    (req_distance_mm),
      .req_object_temp    (req_object_temp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_announce       (rsp_announce),
      .rsp_announced_temp (rsp_announced_temp),
      .rsp_relay_on       (rsp_relay_on),
      .rsp_prompt         (rsp_prompt),
      .rsp_sample_taken   (rsp_sample_taken),
      .rsp_beep           (rsp_beep),
      .rsp_average_temp   (rsp_average_temp),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic reading_type advance_averager(input logic [DIST_W-1:0] distance,
                                                    input logic signed [TEMP_W-1:0] temp);
      reading_type r;
      longint   adj;
      longint   comp;
      r = '0;
      if (streak > WINDOW - 1) begin
         r.announce       = 1'b1;
         r.announced_temp = held_avg;
         r.relay_on       = held_avg < cfg_threshold;
         streak           = 0;
      end
      if (distance > cfg_near_max && distance < cfg_prompt_max)
         r.prompt = 1'b1;
      if (distance > cfg_near_min && distance < cfg_near_max) begin
         adj  = (longint'(distance) * longint'(cfg_gain)) / 256;
         comp = longint'(temp) + adj;
         if (comp > 32767) begin
            comp = 32767;
            saturated_total++;
         end
         if (comp < -32768)
            comp = -32768;
         r.sample_taken = 1'b1;
         win_total -= win_cells[0];
         for (int i = 0; i < WINDOW - 1; i++)
            win_cells[i] = win_cells[i + 1];
         win_cells[WINDOW - 1] = int'(comp);
         win_total += int'(comp);
         held_avg = TEMP_W'(win_total / WINDOW);
         if (streak >= 2)
            r.beep = 1'b1;
         streak++;
      end else begin
         streak = 0;
      end
      r.average_temp = held_avg;
      return r;
   endfunction

   function automatic logic [DIST_W-1:0] between_bounds(input int lo, input int hi);
      return DIST_W'($urandom_range(lo + 1, hi - 1));
   endfunction

   function automatic logic signed [TEMP_W-1:0] draw_temp();
      case ($urandom_range(0, 5))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2, 3: return TEMP_W'($urandom_range(2800, 4200));
         default: return TEMP_W'($urandom);
      endcase
   endfunction

   task automatic store_reg(input logic [IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      case (idx)
         REG_NEAR_MIN:   cfg_near_min = data[DIST_W-1:0];
         REG_NEAR_MAX:   cfg_near_max = data[DIST_W-1:0];
         REG_PROMPT_MAX: cfg_prompt_max = data[DIST_W-1:0];
         REG_GAIN:       cfg_gain = data;
         REG_THRESHOLD:  cfg_threshold = data;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [DIST_W-1:0] nmin, input logic [DIST_W-1:0] nmax,
                                input logic [DIST_W-1:0] pmax, input logic [GAIN_W-1:0] gain,
                                input logic signed [TEMP_W-1:0] thr);
      logic [IDX_W-1:0] idx [6];
      logic [CSR_W-1:0] data [6];
      idx[0] = REG_NEAR_MIN;   data[0] = {3'($urandom), nmin};
      idx[1] = REG_NEAR_MAX;   data[1] = {3'($urandom), nmax};
      idx[2] = REG_PROMPT_MAX; data[2] = {3'($urandom), pmax};
      idx[3] = REG_GAIN;       data[3] = gain;
      idx[4] = REG_THRESHOLD;  data[4] = thr;
      // an index past the last register must leave everything alone
      idx[5] = REG_THRESHOLD + IDX_W'($urandom_range(1, 3));
      data[5] = CSR_W'($urandom);
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= data[i];
         @(posedge clock);
         store_reg(idx[i], data[i]);
      end
      csr_we <= 1'b0;
      settings_used++;
   endtask

   task automatic present_tick(input logic [DIST_W-1:0] distance,
                               input logic signed [TEMP_W-1:0] temp,
                               input logic known, input reading_type want);
      reading_type got;
      if (items_sent < 550) begin
         send_idle_pct = 7;
         rcv_idle_pct <= 69;
      end else if (items_sent < 1100) begin
         send_idle_pct = 69;
         rcv_idle_pct <= 7;
      end else begin
         send_idle_pct = 0;
         rcv_idle_pct <= 0;
         if (!hold_asked) begin
            hold_asked = 1;
            hold_trigger <= 1'b1;
         end
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_distance_mm <= distance;
      req_object_temp <= temp;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      got = advance_averager(distance, temp);
      pending_readings.push_back(known ? want : got);
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_reading();
      reading_type want;
      if (pending_readings.size() == 0) begin
         $error("result item with no item outstanding");
         mismatches++;
         return;
      end
      want = pending_readings.pop_front();
      compare_field("announce", want.announce, rsp_announce);
      compare_field("announced_temp", want.announced_temp, rsp_announced_temp);
      compare_field("relay_on", want.relay_on, rsp_relay_on);
      compare_field("prompt", want.prompt, rsp_prompt);
      compare_field("sample_taken", want.sample_taken, rsp_sample_taken);
      compare_field("beep", want.beep, rsp_beep);
      compare_field("average_temp", want.average_temp, rsp_average_temp);
      checked_total++;
      announce_seen += rsp_announce;
      relay_seen += rsp_relay_on;
      beep_seen += rsp_beep;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_reading();
         if (hold_trigger && !hold_taken) begin
            hold_taken = 1;
            hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
         end
      end
   end

   initial begin
      int                       run_len;
      int                       in_phase;
      int                       lo;
      int                       hi;
      int                       top;
      logic        [DIST_W-1:0] nmin;
      logic        [DIST_W-1:0] nmax;
      logic        [DIST_W-1:0] pmax;
      logic        [GAIN_W-1:0] gain;
      logic signed [TEMP_W-1:0] thr;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PLAN_ROWS; i++)
         present_tick(TICK_PLAN[i].distance, TICK_PLAN[i].temp, TICK_PLAN[i].known,
                      TICK_PLAN[i].want);
      drain_results();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin nmin = 50;   nmax = 180;  pmax = 400;  gain = 256;   thr = 3500;   end
            1: begin nmin = 0;    nmax = 8191; pmax = 8191; gain = 65535; thr = 32767;  end
            2: begin nmin = 0;    nmax = 0;    pmax = 0;    gain = 0;     thr = -32768; end
            3: begin nmin = 4000; nmax = 100;  pmax = 50;   gain = 1234;  thr = 0;      end
            4: begin nmin = 10;   nmax = 2000; pmax = 8191; gain = 0;     thr = -32768; end
            5: begin nmin = 8189; nmax = 8191; pmax = 8191; gain = 65535; thr = -1;     end
            default: begin
               lo   = $urandom_range(0, 2000);
               hi   = lo + $urandom_range(2, 3000);
               top  = hi + $urandom_range(0, 3000);
               nmin = lo;
               nmax = hi;
               pmax = (top > 8191) ? 8191 : top;
               gain = GAIN_W'($urandom);
               thr  = TEMP_W'($urandom);
            end
         endcase
         apply_setting(nmin, nmax, pmax, gain, thr);

         in_phase = 0;
         while (in_phase < PHASE_ITEMS) begin
            if (int'(cfg_near_max) > int'(cfg_near_min) + 1 && $urandom_range(0, 99) < 80) begin
               run_len = $urandom_range(0, 1) ? $urandom_range(8, 11) : $urandom_range(1, 7);
               repeat (run_len)
                  present_tick(between_bounds(cfg_near_min, cfg_near_max), draw_temp(),
                               1'b0, QUIET);
               // a run ends on a prompt-window or stray distance
               if (int'(cfg_prompt_max) > int'(cfg_near_max) + 1 && $urandom_range(0, 1))
                  present_tick(between_bounds(cfg_near_max, cfg_prompt_max), draw_temp(),
                               1'b0, QUIET);
               else
                  present_tick(DIST_W'($urandom), draw_temp(), 1'b0, QUIET);
               in_phase += run_len + 1;
            end else begin
               present_tick(DIST_W'($urandom), draw_temp(), 1'b0, QUIET);
               in_phase++;
            end
         end
         drain_results();
      end

      $display("%0d result items checked under %0d register settings, with idling on both sides",
               checked_total, settings_used + 1);
      $display("%0d announcements (%0d with relay), %0d beeps, %0d saturated samples",
               announce_seen, relay_seen, beep_seen, saturated_total);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/pgta_pkg.sv
rtl/pgta_cell.sv
rtl/pgta_comp.sv
rtl/proximity_gated_temperature_averager.sv
bench/tb_proximity_gated_temperature_averager.sv
